// ===== rtl/rfad_pkg.sv =====
// ----------------------------------------------------------------------------
// rfad_pkg: shared types and constants for the reduced fraction add/divide unit
// Beat payload structs, operation codes and the default operand width.
// ----------------------------------------------------------------------------
package rfad_pkg;

  localparam int unsigned RFAD_WIDTH = 63;
  localparam int unsigned DIV_W      = 32;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_DIV = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [62:0] a_num;
    logic [62:0] a_den;
    logic [62:0] b_num;
    logic [62:0] b_den;
    logic [31:0] divisor;
  } rfad_in_t;

  typedef struct packed {
    logic [62:0] res_num;
    logic [62:0] res_den;
    logic        overflow;
  } rfad_out_t;

  // shared arithmetic unit operation codes
  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;
  localparam logic [1:0] OP_REM = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } rfad_cmd_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } rfad_sts_t;

endpackage

// ===== rtl/rfad_alu.sv =====
// ----------------------------------------------------------------------------
// rfad_alu: bit-serial multiply / divide unit
// One bit per cycle: shift-add multiply with overflow detect, restoring
// divide giving quotient and remainder.
// ----------------------------------------------------------------------------
module rfad_alu import rfad_pkg::*; #(
  parameter int unsigned WIDTH = RFAD_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rfad_cmd_t        cmd_i,
  input  logic [WIDTH-1:0] x_i,
  input  logic [WIDTH-1:0] y_i,
  output logic [WIDTH-1:0] res_o,
  output rfad_sts_t        sts_o
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic             busy_q, busy_d;
  logic [1:0]       op_q, op_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [WIDTH-1:0] acc_q, acc_d;   // product or remainder
  logic [WIDTH-1:0] sh_q, sh_d;     // multiplier bits or dividend/quotient
  logic [WIDTH-1:0] y_q, y_d;
  logic             ovf_q, ovf_d;
  logic             done_q, done_d;

  logic [WIDTH:0]   dbl, sum, trial;

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    y_d    = y_q;
    ovf_d  = ovf_q;
    done_d = 1'b0;
    dbl    = {acc_q, 1'b0};
    sum    = '0;
    trial  = {acc_q, sh_q[WIDTH-1]} - {1'b0, y_q};
    if (cmd_i.start) begin
      busy_d = 1'b1;
      op_d   = cmd_i.op;
      cnt_d  = CW'(WIDTH);
      acc_d  = '0;
      sh_d   = x_i;
      y_d    = y_i;
      ovf_d  = 1'b0;
    end else if (busy_q) begin
      if (op_q == OP_MUL) begin
        // msb-first shift-add of y by the bits of sh
        sum = dbl + (sh_q[WIDTH-1] ? {1'b0, y_q} : '0);
        if (dbl[WIDTH] || sum[WIDTH]) ovf_d = 1'b1;
        acc_d = sum[WIDTH-1:0];
        sh_d  = {sh_q[WIDTH-2:0], 1'b0};
      end else begin
        if (!trial[WIDTH]) begin
          acc_d = trial[WIDTH-1:0];
          sh_d  = {sh_q[WIDTH-2:0], 1'b1};
        end else begin
          acc_d = {acc_q[WIDTH-2:0], sh_q[WIDTH-1]};
          sh_d  = {sh_q[WIDTH-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    y_q   <= y_d;
    ovf_q <= ovf_d;
  end

  always_comb begin
    case (op_q)
      OP_MUL:  res_o = acc_q;
      OP_DIV:  res_o = sh_q;
      OP_REM:  res_o = acc_q;
      default: res_o = acc_q;
    endcase
  end

  assign sts_o.done = done_q;
  assign sts_o.ovf  = ovf_q;

endmodule

// ===== rtl/reduced_fraction_add_divide.sv =====
// ----------------------------------------------------------------------------
// reduced_fraction_add_divide: unsigned rational add / divide with reduction
//
//  channel | direction | valid   | stall   | payload
//  in      | input     | valid_i | stall_o | in_i  (rfad_in_t)
//  out     | output    | valid_o | stall_i | out_o (rfad_out_t)
//
// Every multiply, divide and gcd remainder runs on one shared bit-serial unit.
// A zero denominator or divisor is flagged as overflow from the idle state without
// using the unit; a full add runs two gcd loops, about 90 remainders each worst case.
// One item at a time; the next input beat is taken once the result register
// is free. Reset clears control only. A stalled result holds in out_o.
// ----------------------------------------------------------------------------
module reduced_fraction_add_divide import rfad_pkg::*; #(
  parameter int unsigned WIDTH = RFAD_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      stall_o,
  input  rfad_in_t  in_i,
  output logic      valid_o,
  input  logic      stall_i,
  output rfad_out_t out_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_G1    = 4'd1;  // gcd(ad, bd)
  localparam logic [3:0] S_L1    = 4'd2;  // ad / g
  localparam logic [3:0] S_L2    = 4'd3;  // l = (ad/g) * bd
  localparam logic [3:0] S_SA1   = 4'd4;  // l / ad
  localparam logic [3:0] S_SA2   = 4'd5;  // an * (l/ad)
  localparam logic [3:0] S_SB1   = 4'd6;  // l / bd
  localparam logic [3:0] S_SB2   = 4'd7;  // bn * (l/bd)
  localparam logic [3:0] S_DM    = 4'd8;  // ad * dv
  localparam logic [3:0] S_G2    = 4'd9;  // gcd(num, den)
  localparam logic [3:0] S_RN    = 4'd10; // num / g
  localparam logic [3:0] S_RD    = 4'd11; // den / g
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]       st_q, st_d;
  logic             wait_q, wait_d;   // unit operation in flight
  logic [WIDTH-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic [WIDTH-1:0] p_q, p_d, q_q, q_d, l_q, l_d, t_q, t_d;
  logic             ov_d;
  logic             ovld_q, ovld_d;
  rfad_out_t        res_q, res_d;

  rfad_cmd_t        cmd;
  rfad_sts_t        sts;
  logic [WIDTH-1:0] ux, uy, ures;
  logic [WIDTH:0]   ssum;
  logic [WIDTH-1:0] dvw;
  logic             dv_hi;            // divisor bits above the operand width

  rfad_alu #(.WIDTH(WIDTH)) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .x_i    (ux),
    .y_i    (uy),
    .res_o  (ures),
    .sts_o  (sts)
  );

  assign stall_o = (st_q != S_IDLE) || ovld_q;
  assign valid_o = ovld_q;
  assign out_o   = res_q;

  if (WIDTH >= DIV_W) begin : g_dv_wide
    assign dvw   = WIDTH'(in_i.divisor);
    assign dv_hi = 1'b0;
  end else begin : g_dv_narrow
    assign dvw   = in_i.divisor[WIDTH-1:0];
    assign dv_hi = |in_i.divisor[DIV_W-1:WIDTH];
  end

  always_comb begin
    st_d   = st_q;
    wait_d = wait_q;
    an_d = an_q; ad_d = ad_q; bn_d = bn_q; bd_d = bd_q;
    p_d = p_q; q_d = q_q; l_d = l_q; t_d = t_q;
    ovld_d = ovld_q;
    res_d  = res_q;
    ov_d   = 1'b0;
    cmd.start = 1'b0;
    cmd.op    = OP_MUL;
    ux = '0;
    uy = '0;
    ssum = {1'b0, t_q} + {1'b0, ures};
    if (ovld_q && !stall_i) ovld_d = 1'b0;

    case (st_q)
      S_IDLE: begin
        if (valid_i && !ovld_q) begin
          an_d = in_i.a_num[WIDTH-1:0];
          ad_d = in_i.a_den[WIDTH-1:0];
          bn_d = in_i.b_num[WIDTH-1:0];
          bd_d = in_i.b_den[WIDTH-1:0];
          wait_d = 1'b0;
          if (in_i.mode == MODE_ADD) begin
            if (in_i.a_den[WIDTH-1:0] == '0 || in_i.b_den[WIDTH-1:0] == '0) begin
              ov_d = 1'b1;
              st_d = S_OUT;
            end else begin
              p_d  = in_i.a_den[WIDTH-1:0];
              q_d  = in_i.b_den[WIDTH-1:0];
              st_d = S_G1;
            end
          end else begin
            // a divisor wider than the operands overflows any nonzero denominator
            if (in_i.a_den[WIDTH-1:0] == '0 || in_i.divisor == '0 || dv_hi) begin
              ov_d = 1'b1;
              st_d = S_OUT;
            end else begin
              st_d = S_DM;
              t_d  = dvw;
            end
          end
          if (ov_d) begin
            res_d.res_num  = '0;
            res_d.res_den  = 63'd1;
            res_d.overflow = 1'b1;
            st_d   = S_IDLE;
            ovld_d = 1'b1;
          end
        end
      end
      S_G1, S_G2: begin
        // Euclid: one remainder per step
        if (!wait_q) begin
          if (q_q == '0) begin
            t_d  = p_q;  // gcd
            st_d = (st_q == S_G1) ? S_L1 : S_RN;
          end else begin
            cmd.start = 1'b1; cmd.op = OP_REM; ux = p_q; uy = q_q;
            wait_d = 1'b1;
          end
        end else if (sts.done) begin
          p_d = q_q; q_d = ures; wait_d = 1'b0;
        end
      end
      S_L1: begin
        if (!wait_q) begin
          cmd.start = 1'b1; cmd.op = OP_DIV; ux = ad_q; uy = t_q; wait_d = 1'b1;
        end else if (sts.done) begin
          l_d = ures; wait_d = 1'b0; st_d = S_L2;
        end
      end
      S_L2: begin
        if (!wait_q) begin
          cmd.start = 1'b1; cmd.op = OP_MUL; ux = l_q; uy = bd_q; wait_d = 1'b1;
        end else if (sts.done) begin
          wait_d = 1'b0;
          if (sts.ovf) begin
            st_d = S_OUT; res_d.overflow = 1'b1;
          end else begin
            l_d = ures; st_d = S_SA1;
          end
        end
      end
      S_SA1, S_SB1: begin
        if (!wait_q) begin
          cmd.start = 1'b1; cmd.op = OP_DIV; ux = l_q;
          uy = (st_q == S_SA1) ? ad_q : bd_q; wait_d = 1'b1;
        end else if (sts.done) begin
          p_d = ures; wait_d = 1'b0;
          st_d = (st_q == S_SA1) ? S_SA2 : S_SB2;
        end
      end
      S_SA2: begin
        if (!wait_q) begin
          cmd.start = 1'b1; cmd.op = OP_MUL; ux = an_q; uy = p_q; wait_d = 1'b1;
        end else if (sts.done) begin
          wait_d = 1'b0;
          if (sts.ovf) begin
            st_d = S_OUT; res_d.overflow = 1'b1;
          end else begin
            t_d = ures; st_d = S_SB1;
          end
        end
      end
      S_SB2: begin
        if (!wait_q) begin
          cmd.start = 1'b1; cmd.op = OP_MUL; ux = bn_q; uy = p_q; wait_d = 1'b1;
        end else if (sts.done) begin
          wait_d = 1'b0;
          if (sts.ovf || ssum[WIDTH]) begin
            st_d = S_OUT; res_d.overflow = 1'b1;
          end else begin
            an_d = ssum[WIDTH-1:0];  // result numerator
            ad_d = l_q;              // result denominator
            p_d  = ssum[WIDTH-1:0];
            q_d  = l_q;
            res_d.overflow = 1'b0;
            st_d = (ssum[WIDTH-1:0] == '0) ? S_OUT : S_G2;
          end
        end
      end
      S_DM: begin
        if (!wait_q) begin
          cmd.start = 1'b1; cmd.op = OP_MUL; ux = ad_q; uy = t_q; wait_d = 1'b1;
        end else if (sts.done) begin
          wait_d = 1'b0;
          if (sts.ovf) begin
            st_d = S_OUT; res_d.overflow = 1'b1;
          end else begin
            ad_d = ures; p_d = an_q; q_d = ures;
            res_d.overflow = 1'b0;
            st_d = (an_q == '0) ? S_OUT : S_G2;
          end
        end
      end
      S_RN, S_RD: begin
        if (!wait_q) begin
          cmd.start = 1'b1; cmd.op = OP_DIV;
          ux = (st_q == S_RN) ? an_q : ad_q; uy = t_q; wait_d = 1'b1;
        end else if (sts.done) begin
          wait_d = 1'b0;
          if (st_q == S_RN) begin
            an_d = ures; st_d = S_RD;
          end else begin
            ad_d = ures; st_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (res_q.overflow || an_q == '0) begin
          res_d.res_num = '0;
          res_d.res_den = 63'd1;
        end else begin
          res_d.res_num = 63'(an_q);
          res_d.res_den = 63'(ad_q);
        end
        ovld_d = 1'b1;
        st_d   = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      wait_q <= 1'b0;
      ovld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      wait_q <= wait_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    an_q <= an_d; ad_q <= ad_d; bn_q <= bn_d; bd_q <= bd_d;
    p_q <= p_d; q_q <= q_d; l_q <= l_d; t_q <= t_d;
    res_q <= res_d;
  end

endmodule
